@@ hw/rtl/r0split_pkg.sv @@
// ----------------------------------------------------------------------------
// RAID-0 request splitter package
// Sequencer states, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package r0split_pkg;

  localparam int unsigned TimeW   = 63;
  localparam int unsigned BlockW  = 32;
  localparam int unsigned LenInW  = 13;
  localparam int unsigned StripW  = 17;
  localparam int unsigned DcountW = 5;
  localparam int unsigned DiskOutW = 4;
  localparam int unsigned OffOutW  = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [StripW-1:0] StripMin = 17'd128;
  localparam logic [StripW-1:0] StripMax = 17'd65536;

  localparam logic [CfgIdxW-1:0] CFG_STRIP_BLOCKS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DISK_COUNT      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CAPACITY_BLOCKS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_DIV,
    ST_DISK,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

@@ hw/rtl/raid0_request_splitter_core.sv @@
// ----------------------------------------------------------------------------
// RAID-0 request splitter core
// Wraps a host request at the array capacity and cuts it into strip pieces.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid_i/in_stall_o| time, start, length, is_read
//  out     | output    | out_valid_o/out_stall_i | one strip piece
//  cfg     | input     | cfg_we_i             | cfg_index_i, cfg_wdata_i
//
// A request's setup runs through the shared restoring divider (capacity
// modulo, stripe divide, disk divide), then one piece per cycle while
// out_stall_i does not hold the output. Zero capacity skips the modulo pass;
// a zero length is taken with no piece. Reset loads default registers and idles the sequencer.
// out_stall_i holds the current piece; in_stall_o is high while busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module raid0_request_splitter_core import r0split_pkg::*; #(
  parameter int unsigned MAX_DISKS          = 16,
  parameter int unsigned MAX_REQUEST_BLOCKS = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [BlockW-1:0]  cfg_wdata_i,

  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [TimeW-1:0]   arrival_time_i,
  input  wire logic [BlockW-1:0]  start_block_i,
  input  wire logic [LenInW-1:0]  length_blocks_i,
  input  wire logic               is_read_i,

  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [DiskOutW-1:0]     disk_index_o,
  output logic [BlockW-1:0]       disk_block_o,
  output logic [StripW-1:0]       piece_length_o,
  output logic [BlockW-1:0]       stripe_index_o,
  output logic [OffOutW-1:0]      piece_offset_o,
  output logic                    piece_operation_o,
  output logic [TimeW-1:0]        piece_time_o,
  output logic                    last_piece_o
);

  localparam int unsigned DW  = $clog2(MAX_DISKS);
  localparam int unsigned DCW = $clog2(MAX_DISKS + 1);
  localparam int unsigned RW  = $clog2(MAX_REQUEST_BLOCKS + 1);
  localparam int unsigned SLW = StripW + DCW;
  localparam int unsigned DiskShift = BlockW - DW;

  // configuration
  logic [StripW-1:0]  strip_cfg_q;
  logic [DcountW-1:0] dcount_cfg_q;
  logic [BlockW-1:0]  cap_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_cfg_q  <= StripMin;
      dcount_cfg_q <= 5'd4;
      cap_cfg_q    <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STRIP_BLOCKS:    strip_cfg_q  <= cfg_wdata_i[StripW-1:0];
        CFG_DISK_COUNT:      dcount_cfg_q <= cfg_wdata_i[DcountW-1:0];
        CFG_CAPACITY_BLOCKS: cap_cfg_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective sizes
  logic [StripW-1:0] strip_eff;
  logic [DCW-1:0]    disks_eff;
  logic [RW-1:0]     len_eff;
  logic [31:0]       dcount_ext;
  logic [31:0]       len_in_ext;

  assign dcount_ext = 32'(dcount_cfg_q);
  assign len_in_ext = 32'(length_blocks_i);

  always_comb begin
    if (strip_cfg_q < StripMin) begin
      strip_eff = StripMin;
    end else if (strip_cfg_q > StripMax) begin
      strip_eff = StripMax;
    end else begin
      strip_eff = strip_cfg_q;
    end
    if (dcount_ext == 32'd0) begin
      disks_eff = DCW'(1);
    end else if (dcount_ext > 32'(MAX_DISKS)) begin
      disks_eff = DCW'(MAX_DISKS);
    end else begin
      disks_eff = DCW'(dcount_ext);
    end
    if (len_in_ext > 32'(MAX_REQUEST_BLOCKS)) begin
      len_eff = RW'(MAX_REQUEST_BLOCKS);
    end else begin
      len_eff = RW'(len_in_ext);
    end
  end

  // sequencer
  state_e state_q, state_d;
  logic   in_accept;
  logic   emit;
  logic   piece_last;
  logic [4:0] cnt_q;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept && (len_eff != '0)) begin
          state_d = (cap_cfg_q == '0) ? ST_DIV : ST_MOD;
        end
      end
      ST_MOD: begin
        if (cnt_q == '0) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == '0) state_d = ST_DISK;
      end
      ST_DISK: begin
        if (cnt_q == '0) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit && piece_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    emit       = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_EMIT: emit = !out_valid_o || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request context
  logic [TimeW-1:0]  time_q;
  logic              op_q;
  logic [RW-1:0]     remain_q;
  logic [StripW-1:0] strip_q;
  logic [DCW-1:0]    disks_q;
  logic [SLW-1:0]    stripe_len_q;

  // shared restoring divider
  logic [BlockW-1:0] num_q;
  logic [BlockW-1:0] rem_q;
  logic [BlockW-1:0] acc_q;
  logic [BlockW-1:0] divisor;
  logic [BlockW:0]   shifted;
  logic [BlockW+1:0] diff;
  logic              qbit;
  logic [BlockW-1:0] step_rem;
  logic [BlockW-1:0] step_num;
  logic [BlockW-1:0] step_acc;

  always_comb begin
    case (state_q)
      ST_MOD:  divisor = cap_cfg_q;
      ST_DIV:  divisor = BlockW'(stripe_len_q);
      default: divisor = BlockW'(strip_q);
    endcase
  end

  assign shifted  = {rem_q, num_q[BlockW-1]};
  assign diff     = {1'b0, shifted} - {2'b00, divisor};
  assign qbit     = !diff[BlockW+1];
  assign step_rem = qbit ? diff[BlockW-1:0] : shifted[BlockW-1:0];
  assign step_num = {num_q[BlockW-2:0], qbit};
  assign step_acc = {acc_q[BlockW-2:0], 1'b0} + (qbit ? BlockW'(strip_q) : '0);

  // piece generation
  logic [DW-1:0]     disk_q;
  logic [StripW-1:0] offset_q;
  logic [BlockW-1:0] stripe_q;
  logic [BlockW-1:0] base_q;
  logic [StripW-1:0] room;
  logic [31:0]       remain_ext;
  logic [31:0]       room_ext;
  logic [31:0]       len_ext;
  logic [31:0]       disk_next;
  logic              disk_wrap;

  assign room       = strip_q - offset_q;
  assign remain_ext = 32'(remain_q);
  assign room_ext   = 32'(room);
  assign len_ext    = (remain_ext < room_ext) ? remain_ext : room_ext;
  assign piece_last = (remain_ext == len_ext);
  assign disk_next  = 32'(disk_q) + 32'd1;
  assign disk_wrap  = (disk_next == 32'(disks_q));

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          time_q       <= arrival_time_i;
          op_q         <= is_read_i;
          remain_q     <= len_eff;
          strip_q      <= strip_eff;
          disks_q      <= disks_eff;
          stripe_len_q <= SLW'(strip_eff) * SLW'(disks_eff);
          num_q        <= start_block_i;
          rem_q        <= '0;
          acc_q        <= '0;
          cnt_q        <= 5'd31;
        end
      end
      ST_MOD: begin
        if (cnt_q == '0) begin
          num_q <= step_rem;
          rem_q <= '0;
          acc_q <= '0;
          cnt_q <= 5'd31;
        end else begin
          cnt_q <= cnt_q - 5'd1;
          num_q <= step_num;
          rem_q <= step_rem;
        end
      end
      ST_DIV: begin
        acc_q <= step_acc;
        if (cnt_q == '0) begin
          stripe_q <= step_num;
          base_q   <= step_acc;
          rem_q    <= step_rem >> DW;
          num_q    <= step_rem << DiskShift;
          cnt_q    <= 5'(DW - 1);
        end else begin
          cnt_q <= cnt_q - 5'd1;
          num_q <= step_num;
          rem_q <= step_rem;
        end
      end
      ST_DISK: begin
        cnt_q <= cnt_q - 5'd1;
        num_q <= step_num;
        rem_q <= step_rem;
        if (cnt_q == '0) begin
          disk_q   <= step_num[DW-1:0];
          offset_q <= step_rem[StripW-1:0];
        end
      end
      ST_EMIT: begin
        if (emit) begin
          remain_q <= RW'(remain_ext - len_ext);
          offset_q <= '0;
          if (disk_wrap) begin
            disk_q   <= '0;
            stripe_q <= stripe_q + 32'd1;
            base_q   <= base_q + BlockW'(strip_q);
          end else begin
            disk_q <= DW'(disk_next);
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  logic [31:0] disk_ext;
  assign disk_ext = 32'(disk_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      disk_index_o      <= disk_ext[DiskOutW-1:0];
      disk_block_o      <= base_q + BlockW'(offset_q);
      piece_length_o    <= len_ext[StripW-1:0];
      stripe_index_o    <= stripe_q;
      piece_offset_o    <= offset_q[OffOutW-1:0];
      piece_operation_o <= op_q;
      piece_time_o      <= time_q;
      last_piece_o      <= piece_last;
    end
  end

endmodule

`default_nettype wire
